@@ design/bvcc_pkg.sv @@
// Shared widths, decision codes, register indexes and the control word
// that travels down the view-cone culling pipeline. No dependencies.
package bvcc_pkg;

  localparam int POS_W    = 24;
  localparam int DIFF_W   = 25;
  localparam int VEC_W    = 48;
  localparam int COMP_W   = 16;
  localparam int RD_W     = 23;
  localparam int TAN_W    = 32;
  localparam int HTAN_W   = 16;
  localparam int SQ_W     = 49;
  localparam int DSQ_W    = 50;
  localparam int ROOT_W   = 46;
  localparam int DIST_W   = 23;
  localparam int PROD_W   = 41;
  localparam int DOT_W    = 42;
  localparam int MAG_W    = 41;
  localparam int QUO_W    = 26;
  localparam int MARGIN_W = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;

  localparam logic [DSQ_W-1:0] NEAR_SQ = DSQ_W'(225) << 16;

  typedef enum logic [2:0] {
    DEC_FAR   = 3'd0,
    DEC_NEAR  = 3'd1,
    DEC_BEHIND = 3'd2,
    DEC_HORIZ = 3'd3,
    DEC_VERT  = 3'd4,
    DEC_INSIDE = 3'd5
  } decision_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAM_X   = 4'd0,
    CFG_CAM_Y   = 4'd1,
    CFG_CAM_Z   = 4'd2,
    CFG_FORWARD = 4'd3,
    CFG_RIGHT   = 4'd4,
    CFG_UP      = 4'd5,
    CFG_RDIST   = 4'd6,
    CFG_TAN     = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic             far;
    logic             near;
    logic             fpos;
    logic [MAG_W-1:0] f_mag;
    logic [MAG_W-1:0] r_mag;
    logic [MAG_W-1:0] u_mag;
  } ctl_t;

  function automatic logic signed [COMP_W-1:0] vcomp(input logic [VEC_W-1:0] v,
                                                     input int i);
    vcomp = $signed(v[i*COMP_W +: COMP_W]);
  endfunction

endpackage

@@ design/bvcc_in_if.sv @@
// Input channel: one block position word with valid/ready.
// Depends on bvcc_pkg.
interface bvcc_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [bvcc_pkg::POS_W-1:0] block_x;
  logic signed [bvcc_pkg::POS_W-1:0] block_y;
  logic signed [bvcc_pkg::POS_W-1:0] block_z;
  modport source(output valid, block_x, block_y, block_z, input ready);
  modport sink(input valid, block_x, block_y, block_z, output ready);
endinterface

@@ design/bvcc_out_if.sv @@
// Output channel: one culling result word with valid/ready.
// Depends on nothing.
interface bvcc_out_if;
  logic       valid;
  logic       ready;
  logic       visible;
  logic [2:0] decision;
  modport source(output valid, visible, decision, input ready);
  modport sink(input valid, visible, decision, output ready);
endinterface

@@ design/block_view_cone_cull.sv @@
// Per-block view-cone culling: camera registers, a 58-stage pipeline and
// the output register. Depends on bvcc_pkg, bvcc_in_if, bvcc_out_if,
// bvcc_front, bvcc_sqrt and bvcc_margin.
// Throughput: one word per cycle; the pipeline advances as one unit and
// holds while the output word waits. Reset clears all valid bits and the
// camera registers to zero; there is no clearing pass.
module block_view_cone_cull (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bvcc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bvcc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  bvcc_in_if.sink                           in_i,
  bvcc_out_if.source                        out_o
);
  import bvcc_pkg::*;

  logic signed [POS_W-1:0] cam_x_q, cam_y_q, cam_z_q;
  logic [VEC_W-1:0]        fwd_q, right_q, up_q;
  logic [RD_W-1:0]         rdist_q;
  logic [TAN_W-1:0]        tan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
      fwd_q   <= '0;
      right_q <= '0;
      up_q    <= '0;
      rdist_q <= '0;
      tan_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CAM_X:   cam_x_q <= cfg_data_i[POS_W-1:0];
        CFG_CAM_Y:   cam_y_q <= cfg_data_i[POS_W-1:0];
        CFG_CAM_Z:   cam_z_q <= cfg_data_i[POS_W-1:0];
        CFG_FORWARD: fwd_q   <= cfg_data_i[VEC_W-1:0];
        CFG_RIGHT:   right_q <= cfg_data_i[VEC_W-1:0];
        CFG_UP:      up_q    <= cfg_data_i[VEC_W-1:0];
        CFG_RDIST:   rdist_q <= cfg_data_i[RD_W-1:0];
        CFG_TAN:     tan_q   <= cfg_data_i[TAN_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  logic out_vis_q;
  logic [2:0] out_dec_q;

  assign en          = !out_valid_q || out_o.ready;
  assign in_i.ready  = en;

  logic              fr_v, sq_v, mg_v;
  logic [ROOT_W-1:0] fr_dsq;
  logic [DIST_W-1:0] sq_dist;
  logic [MARGIN_W-1:0] mg_m;
  ctl_t              fr_ctl, sq_ctl, mg_ctl;

  bvcc_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid),
    .blk_x_i(in_i.block_x), .blk_y_i(in_i.block_y), .blk_z_i(in_i.block_z),
    .cam_x_i(cam_x_q), .cam_y_i(cam_y_q), .cam_z_i(cam_z_q),
    .fwd_i(fwd_q), .right_i(right_q), .up_i(up_q), .rdist_i(rdist_q),
    .valid_o(fr_v), .dsq_o(fr_dsq), .ctl_o(fr_ctl)
  );

  bvcc_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fr_v), .dsq_i(fr_dsq), .ctl_i(fr_ctl),
    .valid_o(sq_v), .dist_o(sq_dist), .ctl_o(sq_ctl)
  );

  bvcc_margin u_margin (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_v), .dist_i(sq_dist), .ctl_i(sq_ctl),
    .valid_o(mg_v), .margin_o(mg_m), .ctl_o(mg_ctl)
  );

  localparam int FLO_W = 21;
  localparam int FHI_W = MAG_W - FLO_W;
  localparam int TH_W  = HTAN_W + 1;
  localparam int PLO_W = TH_W + FLO_W;
  localparam int PHI_W = TH_W + FHI_W;
  localparam int RHS_W = PLO_W + FHI_W;

  logic [TH_W-1:0]  th, tv;
  logic [PLO_W-1:0] phl_q, pvl_q;
  logic [PHI_W-1:0] phh_q, pvh_q;
  ctl_t             t_ctl_q;
  logic             t_v_q;
  logic [RHS_W-1:0] rhs_h, rhs_v;
  logic [RHS_W-1:0] lhs_h, lhs_v;
  decision_e        dec;

  always_comb begin
    th = TH_W'(tan_q[TAN_W-1:HTAN_W]) + TH_W'(mg_m);
    tv = TH_W'(tan_q[HTAN_W-1:0]) + TH_W'(mg_m);
    rhs_h = RHS_W'(phl_q) + (RHS_W'(phh_q) << FLO_W);
    rhs_v = RHS_W'(pvl_q) + (RHS_W'(pvh_q) << FLO_W);
    lhs_h = RHS_W'({t_ctl_q.r_mag, 12'b0});
    lhs_v = RHS_W'({t_ctl_q.u_mag, 12'b0});
    if (t_ctl_q.far)        dec = DEC_FAR;
    else if (t_ctl_q.near)  dec = DEC_NEAR;
    else if (!t_ctl_q.fpos) dec = DEC_BEHIND;
    else if (lhs_h > rhs_h) dec = DEC_HORIZ;
    else if (lhs_v > rhs_v) dec = DEC_VERT;
    else                    dec = DEC_INSIDE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_v_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      t_v_q       <= mg_v;
      out_valid_q <= t_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      phl_q     <= PLO_W'(th) * PLO_W'(mg_ctl.f_mag[FLO_W-1:0]);
      phh_q     <= PHI_W'(th) * PHI_W'(mg_ctl.f_mag[MAG_W-1:FLO_W]);
      pvl_q     <= PLO_W'(tv) * PLO_W'(mg_ctl.f_mag[FLO_W-1:0]);
      pvh_q     <= PHI_W'(tv) * PHI_W'(mg_ctl.f_mag[MAG_W-1:FLO_W]);
      t_ctl_q   <= mg_ctl;
      out_dec_q <= dec;
      out_vis_q <= (dec == DEC_NEAR) || (dec == DEC_INSIDE);
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.visible  = out_vis_q;
  assign out_o.decision = out_dec_q;

  a_vis_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_vis_q == ((out_dec_q == DEC_NEAR) || (out_dec_q == DEC_INSIDE))))
    else $error("visible flag disagrees with decision");

  a_dec_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_dec_q <= DEC_INSIDE))
    else $error("decision code out of range");

  a_rise_adv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(en))
    else $error("output word appeared without a pipeline advance");
endmodule

@@ design/bvcc_front.sv @@
// Front stages: offsets, squared distance, the three dot products, and the
// far / near / behind flags. Four register stages. Depends on bvcc_pkg.
module bvcc_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic signed [bvcc_pkg::POS_W-1:0]    blk_x_i,
  input  logic signed [bvcc_pkg::POS_W-1:0]    blk_y_i,
  input  logic signed [bvcc_pkg::POS_W-1:0]    blk_z_i,
  input  logic signed [bvcc_pkg::POS_W-1:0]    cam_x_i,
  input  logic signed [bvcc_pkg::POS_W-1:0]    cam_y_i,
  input  logic signed [bvcc_pkg::POS_W-1:0]    cam_z_i,
  input  logic [bvcc_pkg::VEC_W-1:0]           fwd_i,
  input  logic [bvcc_pkg::VEC_W-1:0]           right_i,
  input  logic [bvcc_pkg::VEC_W-1:0]           up_i,
  input  logic [bvcc_pkg::RD_W-1:0]            rdist_i,
  output logic                                 valid_o,
  output logic [bvcc_pkg::ROOT_W-1:0]          dsq_o,
  output bvcc_pkg::ctl_t                       ctl_o
);
  import bvcc_pkg::*;

  logic signed [DIFF_W-1:0] d_q [3];
  logic signed [DIFF_W-1:0] d_d [3];
  logic [SQ_W-1:0]          sq_q [3];
  logic [SQ_W-1:0]          sq_d [3];
  logic signed [PROD_W-1:0] pf_q [3], pr_q [3], pu_q [3];
  logic signed [PROD_W-1:0] pf_d [3], pr_d [3], pu_d [3];
  logic [DSQ_W-1:0]         dsq_q, dsq_d;
  logic signed [DOT_W-1:0]  f_q, r_q, u_q, f_d, r_d, u_d;
  logic [2:0]               v_q;
  logic                     v4_q;
  logic [ROOT_W-1:0]        dsq4_q;
  ctl_t                     ctl_q, ctl_d;
  logic [DSQ_W-1:0]         rsq;
  logic signed [DSQ_W-1:0]  sqf [3];

  always_comb begin
    d_d[0] = DIFF_W'(blk_x_i) - DIFF_W'(cam_x_i);
    d_d[1] = DIFF_W'(blk_y_i) - DIFF_W'(cam_y_i);
    d_d[2] = DIFF_W'(blk_z_i) - DIFF_W'(cam_z_i);
    for (int i = 0; i < 3; i++) begin
      sqf[i]  = DSQ_W'(d_q[i]) * DSQ_W'(d_q[i]);
      sq_d[i] = sqf[i][SQ_W-1:0];
      pf_d[i] = PROD_W'(d_q[i]) * PROD_W'(vcomp(fwd_i, i));
      pr_d[i] = PROD_W'(d_q[i]) * PROD_W'(vcomp(right_i, i));
      pu_d[i] = PROD_W'(d_q[i]) * PROD_W'(vcomp(up_i, i));
    end
    dsq_d = DSQ_W'(sq_q[0]) + DSQ_W'(sq_q[1]) + DSQ_W'(sq_q[2]);
    f_d = DOT_W'(pf_q[0]) + DOT_W'(pf_q[1]) + DOT_W'(pf_q[2]);
    r_d = DOT_W'(pr_q[0]) + DOT_W'(pr_q[1]) + DOT_W'(pr_q[2]);
    u_d = DOT_W'(pu_q[0]) + DOT_W'(pu_q[1]) + DOT_W'(pu_q[2]);
    rsq = DSQ_W'(rdist_i) * DSQ_W'(rdist_i);
    ctl_d.far   = dsq_q > rsq;
    ctl_d.near  = dsq_q < NEAR_SQ;
    ctl_d.fpos  = !f_q[DOT_W-1] && (f_q != '0);
    ctl_d.f_mag = f_q[MAG_W-1:0];
    ctl_d.r_mag = r_q[DOT_W-1] ? MAG_W'(-r_q) : r_q[MAG_W-1:0];
    ctl_d.u_mag = u_q[DOT_W-1] ? MAG_W'(-u_q) : u_q[MAG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v_q  <= {v_q[1:0], valid_i};
      v4_q <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q    <= d_d;
      sq_q   <= sq_d;
      pf_q   <= pf_d;
      pr_q   <= pr_d;
      pu_q   <= pu_d;
      dsq_q  <= dsq_d;
      f_q    <= f_d;
      r_q    <= r_d;
      u_q    <= u_d;
      ctl_q  <= ctl_d;
      dsq4_q <= dsq_q[ROOT_W-1:0];
    end
  end

  assign valid_o = v4_q;
  assign dsq_o   = dsq4_q;
  assign ctl_o   = ctl_q;
endmodule

@@ design/bvcc_sqrt.sv @@
// Floor square root of the squared distance, one result bit per stage.
// Depends on bvcc_pkg.
module bvcc_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [bvcc_pkg::ROOT_W-1:0] dsq_i,
  input  bvcc_pkg::ctl_t              ctl_i,
  output logic                        valid_o,
  output logic [bvcc_pkg::DIST_W-1:0] dist_o,
  output bvcc_pkg::ctl_t              ctl_o
);
  import bvcc_pkg::*;

  localparam int NST = ROOT_W / 2;

  logic [ROOT_W-1:0] rem_q [NST];
  logic [ROOT_W-1:0] res_q [NST];
  ctl_t              ctl_q [NST];
  logic [NST-1:0]    v_q;

  for (genvar s = 0; s < NST; s++) begin : g_st
    localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * (NST - 1 - s));
    logic [ROOT_W-1:0] rem_in, res_in, sum, rem_d, res_d;
    ctl_t              ctl_in;
    logic              v_in, ge;
    if (s == 0) begin : g_first
      assign rem_in = dsq_i;
      assign res_in = '0;
      assign ctl_in = ctl_i;
      assign v_in   = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign res_in = res_q[s-1];
      assign ctl_in = ctl_q[s-1];
      assign v_in   = v_q[s-1];
    end
    always_comb begin
      sum   = res_in + BIT;
      ge    = rem_in >= sum;
      rem_d = ge ? rem_in - sum : rem_in;
      res_d = ge ? (res_in >> 1) + BIT : res_in >> 1;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        res_q[s] <= res_d;
        ctl_q[s] <= ctl_in;
      end
    end
  end

  assign valid_o = v_q[NST-1];
  assign dist_o  = res_q[NST-1][DIST_W-1:0];
  assign ctl_o   = ctl_q[NST-1];
endmodule

@@ design/bvcc_margin.sv @@
// Angular margin atan(0.5/dist), 8 bits wide on the Q4.12 scale: restoring
// divide of 2^37 by the distance, one quotient bit per stage, then a
// registered odd series. Depends on bvcc_pkg.
module bvcc_margin (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [bvcc_pkg::DIST_W-1:0]   dist_i,
  input  bvcc_pkg::ctl_t                ctl_i,
  output logic                          valid_o,
  output logic [bvcc_pkg::MARGIN_W-1:0] margin_o,
  output bvcc_pkg::ctl_t                ctl_o
);
  import bvcc_pkg::*;

  localparam int REM_W = DIST_W + 1;
  localparam int X2_W  = 2 * QUO_W - 30;
  localparam int X3_W  = X2_W + QUO_W - 30;
  localparam int X5_W  = X3_W + X2_W - 30;
  localparam int Q3_W  = X3_W - 1;
  localparam int Q5_W  = X5_W - 2;
  localparam int A_W   = QUO_W + 1;
  localparam logic [20:0] RCP3 = 21'd699051;
  localparam logic [12:0] RCP5 = 13'd6554;
  localparam logic [REM_W-1:0] REM0 = REM_W'(64'd1 << (37 - QUO_W));

  logic [REM_W-1:0]  rem_q [QUO_W];
  logic [QUO_W-1:0]  quo_q [QUO_W];
  logic [DIST_W-1:0] dv_q  [QUO_W];
  ctl_t              dctl_q [QUO_W];
  logic [QUO_W-1:0]  dvld_q;

  for (genvar s = 0; s < QUO_W; s++) begin : g_div
    logic [REM_W-1:0]  rem_in, t, rem_d;
    logic [QUO_W-1:0]  quo_in;
    logic [DIST_W-1:0] dv_in;
    ctl_t              ctl_in;
    logic              v_in, ge;
    if (s == 0) begin : g_first
      assign rem_in = REM0;
      assign quo_in = '0;
      assign dv_in  = (dist_i == '0) ? DIST_W'(1) : dist_i;
      assign ctl_in = ctl_i;
      assign v_in   = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign dv_in  = dv_q[s-1];
      assign ctl_in = dctl_q[s-1];
      assign v_in   = dvld_q[s-1];
    end
    always_comb begin
      t     = {rem_in[REM_W-2:0], 1'b0};
      ge    = t >= REM_W'(dv_in);
      rem_d = ge ? t - REM_W'(dv_in) : t;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvld_q[s] <= 1'b0;
      end else if (en_i) begin
        dvld_q[s] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        quo_q[s]  <= {quo_in[QUO_W-2:0], ge};
        dv_q[s]   <= dv_in;
        dctl_q[s] <= ctl_in;
      end
    end
  end

  logic [QUO_W-1:0]    x1_q, x2a_q, x3a_q;
  logic [X2_W-1:0]     x2_q, x2b_q;
  logic [X3_W-1:0]     x3_q;
  logic [X5_W-1:0]     x5_q;
  logic [Q3_W-1:0]     q3_q;
  logic [MARGIN_W-1:0] m_q;
  ctl_t                pctl_q [4];
  logic [3:0]          pv_q;
  logic [2*QUO_W-1:0]  p1;
  logic [X2_W+QUO_W-1:0] p2;
  logic [X3_W+X2_W-1:0]  p3;
  logic [X3_W+20:0]      p3r;
  logic [X5_W+12:0]      p5r;
  logic [A_W-1:0]        a;

  always_comb begin
    p1  = (2*QUO_W)'(quo_q[QUO_W-1]) * (2*QUO_W)'(quo_q[QUO_W-1]);
    p2  = (X2_W+QUO_W)'(x2_q) * (X2_W+QUO_W)'(x1_q);
    p3  = (X3_W+X2_W)'(x3_q) * (X3_W+X2_W)'(x2b_q);
    p3r = (X3_W+21)'(x3_q) * (X3_W+21)'(RCP3);
    p5r = (X5_W+13)'(x5_q) * (X5_W+13)'(RCP5);
    a   = A_W'(x3a_q) - A_W'(q3_q) + A_W'(p5r[X5_W+12:15]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else if (en_i) begin
      pv_q <= {pv_q[2:0], dvld_q[QUO_W-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q   <= quo_q[QUO_W-1];
      x2_q   <= p1[2*QUO_W-1:30];
      x2a_q  <= x1_q;
      x2b_q  <= x2_q;
      x3_q   <= p2[X2_W+QUO_W-1:30];
      x3a_q  <= x2a_q;
      x5_q   <= p3[X3_W+X2_W-1:30];
      q3_q   <= p3r[Q3_W+20:21];
      m_q    <= a[QUO_W-1:18];
      pctl_q[0] <= dctl_q[QUO_W-1];
      for (int k = 1; k < 4; k++) pctl_q[k] <= pctl_q[k-1];
    end
  end

  assign valid_o  = pv_q[3];
  assign margin_o = m_q;
  assign ctl_o    = pctl_q[3];
endmodule
